// File: rtl/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;
  localparam int OPERAND_WIDTH = 32;
  localparam int MW = 2 * OPERAND_WIDTH;   // magnitude width of a product
  localparam int SW = MW + 1;              // one more bit for sums
  localparam int CW = 7;                   // bit counter for MW+1 steps

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_MUL = 3'd2,
    MODE_DIV = 3'd3,
    MODE_RED = 3'd4
  } mode_t;

  // request to the shared divider
  typedef struct packed {
    logic          go;
    logic [SW-1:0] dividend;
    logic [SW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [SW-1:0] quot;
    logic [SW-1:0] rem;
  } div_rsp_t;
endpackage

// File: rtl/rau_div.sv
`timescale 1ns / 1ps
module rau_div
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [SW-1:0] q, r, d;
  logic [CW-1:0] cnt;
  logic          run;
  logic          done_r;
  logic [SW:0]   trial;

  // one quotient bit per cycle, restoring
  assign trial = {r, q[SW-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        q <= req.dividend;
        d <= req.divisor;
        r <= '0;
        cnt <= CW'(SW);
        run <= 1'b1;
      end else if (run) begin
        if (!trial[SW]) begin
          r <= trial[SW-1:0];
          q <= {q[SW-2:0], 1'b1};
        end else begin
          r <= {r[SW-2:0], q[SW-1]};
          q <= {q[SW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
  assign rsp.done = done_r;
  assign rsp.quot = q;
  assign rsp.rem  = r;
endmodule

// File: rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// Rational arithmetic unit: combines two signed fractions, or takes the first
// in reduce mode, and reduces by the gcd of the numerator and denominator.
// Input channel: raise start with mode, a_num, a_den, b_num, b_den while busy
// is low; the word is taken at that edge and busy rises on the next cycle.
// Output channel: done is high for exactly one cycle with res_num, res_den
// and the flags; the receiver cannot stall and must take the word then.
// Sequencing: three products, the sum, then every Euclid remainder step and both
// quotient divisions, which go through one shared restoring divider of 65 bits;
// each divider pass is an issue state and a wait state. The passes are the steps
// of the result gcd, the steps of the first-operand gcd and two quotients
// (skipped when both parts are zero); the worst is about 140 passes.
// Flow: busy stays high through the done cycle, so the next word is taken only
// after done has fallen; only one word is in flight.
// Reset (rst, synchronous) returns the sequencer to idle; no word is lost
// other than one in flight, which is dropped.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic [2:0]   mode,
  input  logic [31:0]  a_num,
  input  logic [31:0]  a_den,
  input  logic [31:0]  b_num,
  input  logic [31:0]  b_den,
  output logic         done,
  output logic [63:0]  res_num,
  output logic [63:0]  res_den,
  output logic         zero_den,
  output logic         not_reduced,
  output logic         a_valid,
  output logic         a_lowest,
  output logic         a_positive,
  output logic         a_negative
);
  localparam int OW = OPERAND_WIDTH;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL   = 10'b0000000010,
    S_SUM   = 10'b0000000100,
    S_GSTEP = 10'b0000001000,
    S_GWAIT = 10'b0000010000,
    S_QN    = 10'b0000100000,
    S_QD    = 10'b0001000000,
    S_QWAIT = 10'b0010000000,
    S_ASTEP = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  logic [2:0]    mode_r;
  logic [OW-1:0] anm, adm, bnm, bdm;
  logic          ann, adn, bnn, bdn;
  logic [1:0]    mstep;
  logic [MW-1:0] p_ad, p_bn, p_d;   // p_bn, p_d: products; p_ad: gcd load flag
  logic [MW-1:0] nmag, dmag;
  logic          nneg, dneg;
  logic [SW-1:0] gx, gy;            // gcd operands
  logic          gsec;              // 0: result gcd, 1: first operand gcd
  logic          qsec;              // 0: numerator quotient, 1: denominator
  logic [MW-1:0] g;
  logic          a_low_r;
  div_req_t      req;
  div_rsp_t      rsp;

  // magnitude and sign of an operand
  function automatic logic [OW:0] sm(input logic [31:0] v);
    logic [OW-1:0] m;
    m = v[OW-1:0];
    if (m[OW-1]) return {1'b1, OW'(-m)};
    return {1'b0, m};
  endfunction

  logic [OW-1:0] mx, my;
  logic [MW-1:0] prod;
  assign prod = MW'(mx) * MW'(my);

  // shared multiplier operand select
  always_comb begin
    mx = anm; my = bdm;
    case (mstep)
      2'd0: begin mx = anm; my = (mode_r == MODE_MUL) ? bnm : bdm; end
      2'd1: begin mx = bnm; my = adm; end
      2'd2: begin mx = adm; my = (mode_r == MODE_DIV) ? bnm : bdm; end
      default: begin mx = anm; my = bdm; end
    endcase
  end

  rau_div u_div (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  logic is_arith;
  assign is_arith = (mode_r == MODE_ADD) || (mode_r == MODE_SUB) ||
                    (mode_r == MODE_MUL) || (mode_r == MODE_DIV);

  logic bsign;   // sign of second cross term
  logic [SW-1:0] s_t1, s_t2;

  always_comb begin
    bsign = (p_bn != '0) && (bnn != adn);
    if (mode_r == MODE_SUB && p_bn != '0) bsign = !bsign;
    s_t1 = {1'b0, nmag} + {1'b0, p_bn};
    s_t2 = {1'b0, nmag} - {1'b0, p_bn};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      req.go <= 1'b0;
    end else begin
      done <= 1'b0;
      req.go <= 1'b0;
      case (state)
        S_IDLE: if (start && !busy) begin
          mode_r <= mode;
          {ann, anm} <= sm(a_num);
          {adn, adm} <= sm(a_den);
          {bnn, bnm} <= sm(b_num);
          {bdn, bdm} <= sm(b_den);
          mstep <= 2'd0;
          state <= S_MUL;
        end
        // three products, one per cycle
        S_MUL: begin
          mstep <= mstep + 2'd1;
          case (mstep)
            2'd0: begin
              nmag <= prod;
              nneg <= (prod != '0) &&
                      (ann != ((mode_r == MODE_MUL) ? bnn : bdn));
            end
            2'd1: p_bn <= prod;
            default: begin
              p_d <= prod;
              state <= S_SUM;
            end
          endcase
        end
        // add cross terms, pick the pair to reduce
        S_SUM: begin
          if (is_arith) begin
            dmag <= p_d;
            dneg <= (p_d != '0) &&
                    (adn != ((mode_r == MODE_DIV) ? bnn : bdn));
            if (mode_r == MODE_ADD || mode_r == MODE_SUB) begin
              if (nneg == bsign) begin
                nmag <= s_t1[MW-1:0];
              end else if (!s_t2[SW-1]) begin
                nmag <= s_t2[MW-1:0];
                if (s_t2 == '0) nneg <= 1'b0;
              end else begin
                nmag <= MW'(-s_t2);
                nneg <= bsign;
              end
            end
            gx <= '0; gy <= '0;
          end else begin
            nmag <= MW'(anm); nneg <= ann && (anm != '0);
            dmag <= MW'(adm); dneg <= adn && (adm != '0);
          end
          gsec <= 1'b0;
          state <= S_GSTEP;
          p_ad <= '0;
        end
        // load or continue Euclid
        S_GSTEP: begin
          if (p_ad == '0) begin
            p_ad <= MW'(1);
            if (!gsec) begin gx <= {1'b0, nmag}; gy <= {1'b0, dmag}; end
            else begin gx <= SW'(anm); gy <= SW'(adm); end
          end else if (gx == '0 || gy == '0) begin
            if (!gsec) begin
              g <= MW'(gx + gy);
              gsec <= 1'b1;
              p_ad <= '0;
            end else begin
              a_low_r <= (gx + gy) == SW'(1);
              qsec <= 1'b0;
              state <= (g == '0) ? S_ASTEP : S_QN;
            end
          end else begin
            req.go <= 1'b1;
            req.dividend <= (gx > gy) ? gx : gy;
            req.divisor  <= (gx > gy) ? gy : gx;
            state <= S_GWAIT;
          end
        end
        S_GWAIT: if (rsp.done) begin
          if (gx > gy) gx <= rsp.rem; else gy <= rsp.rem;
          state <= S_GSTEP;
        end
        S_QN: begin
          req.go <= 1'b1;
          req.dividend <= qsec ? {1'b0, dmag} : {1'b0, nmag};
          req.divisor <= {1'b0, g};
          state <= S_QWAIT;
        end
        S_QWAIT: if (rsp.done) begin
          if (!qsec) begin
            nmag <= rsp.quot[MW-1:0];
            qsec <= 1'b1;
            state <= S_QN;
          end else begin
            dmag <= rsp.quot[MW-1:0];
            state <= S_ASTEP;
          end
        end
        // present the result
        S_ASTEP: begin
          res_num <= nneg ? -nmag : nmag;
          res_den <= dneg ? -dmag : dmag;
          zero_den <= (dmag == '0);
          not_reduced <= (g == '0);
          a_valid <= (adm != '0);
          a_lowest <= a_low_r;
          a_positive <= (anm != '0) && (adm != '0) && (ann == adn);
          a_negative <= (anm != '0) && (adm != '0) && (ann != adn);
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE) || done;

  // the divider is never started while it runs
  assert property (@(posedge clk) disable iff (rst)
    req.go |-> (state == S_GWAIT || state == S_QWAIT)) else $error("div go");
  // done only follows the output state
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_OUT)) else $error("done order");
  // a zero gcd always flags a zero denominator
  assert property (@(posedge clk) disable iff (rst)
    (done && not_reduced) |-> zero_den) else $error("flags");
endmodule
